// ----- design/pfgs_pkg.sv -----
package pfgs_pkg;

   // default grid limits
   localparam int DEF_MAX_WIDTH  = 64;
   localparam int DEF_MAX_HEIGHT = 64;

   // operation codes
   localparam logic [1:0] FUNC_INIT = 2'd0;
   localparam logic [1:0] FUNC_STEP = 2'd1;
   localparam logic [1:0] FUNC_READ = 2'd2;

   // csr port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 31;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRICTION    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DAMPING     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_PRESS  = 3'd4;

   // csr reset values
   localparam logic [6:0]  RST_GRID_WIDTH  = 7'd64;
   localparam logic [6:0]  RST_GRID_HEIGHT = 7'd64;
   localparam logic [19:0] RST_FRICTION    = 20'd16384;
   localparam logic [16:0] RST_DAMPING     = 17'd32768;
   localparam logic [30:0] RST_INIT_PRESS  = 31'd65536;

   // one in q16.16
   localparam logic [16:0] Q_ONE = 17'd65536;

   // divider sizing: dividend is |a| shifted up by 16
   localparam int DIV_NUM_W = 48;
   localparam int DIV_STEPS = DIV_NUM_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef struct packed {
      logic [1:0] func;
      logic [5:0] cell_x;
      logic [5:0] cell_y;
   } pfgs_req_type;

   typedef struct packed {
      logic signed [31:0] pressure;
      logic signed [31:0] flow_right;
      logic signed [31:0] flow_down;
      logic               status;
   } pfgs_rsp_type;

   // clamp to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
      if (v > 68'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -68'sd2147483648) begin
         return 32'sh80000000;
      end else begin
         return $signed(v[31:0]);
      end
   endfunction

endpackage

// ----- design/pfgs_ram.sv -----
module pfgs_ram #(
   parameter int AW = 13,
   parameter int DW = 32
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [2**AW];

   // one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- design/pfgs_div.sv -----
module pfgs_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] dividend,
   input  logic signed [31:0] divisor,
   output logic               done,
   output logic signed [31:0] quotient
);
   import pfgs_pkg::*;

   logic                 run_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DIV_NUM_W-1:0] num_ff;
   logic [31:0]          rem_ff;
   logic [31:0]          den_ff;
   logic                 neg_ff;
   logic signed [31:0]   quo_ff;

   logic [31:0]          a_mag;
   logic [31:0]          b_mag;
   logic [32:0]          rem_sh;
   logic                 ge;
   logic [32:0]          rem_sub;
   logic [DIV_NUM_W-1:0] q_mag;
   logic signed [31:0]   q_sat;

   // operand magnitudes
   assign a_mag = dividend[31] ? 32'(-dividend) : 32'(dividend);
   assign b_mag = divisor[31] ? 32'(-divisor) : 32'(divisor);

   // one restoring step
   assign rem_sh  = {rem_ff, num_ff[DIV_NUM_W-1]};
   assign ge      = rem_sh >= {1'b0, den_ff};
   assign rem_sub = rem_sh - {1'b0, den_ff};
   assign q_mag   = {num_ff[DIV_NUM_W-2:0], ge};

   // sign and saturate the final magnitude
   always_comb begin
      if (neg_ff) begin
         if (q_mag > DIV_NUM_W'(64'h80000000)) begin
            q_sat = 32'sh80000000;
         end else begin
            q_sat = $signed(32'(-q_mag));
         end
      end else begin
         if (q_mag > DIV_NUM_W'(64'h7fffffff)) begin
            q_sat = 32'sh7fffffff;
         end else begin
            q_sat = $signed(q_mag[31:0]);
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         run_ff  <= divisor != 32'sd0;
         done_ff <= divisor == 32'sd0;
         cnt_ff  <= '0;
      end else if (run_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            run_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= {a_mag, 16'd0};
         rem_ff <= '0;
         den_ff <= b_mag;
         neg_ff <= dividend[31] ^ divisor[31];
         if (dividend > 32'sd0) begin
            quo_ff <= 32'sh7fffffff;
         end else if (dividend < 32'sd0) begin
            quo_ff <= 32'sh80000000;
         end else begin
            quo_ff <= 32'sd0;
         end
      end else if (run_ff) begin
         rem_ff <= ge ? rem_sub[31:0] : rem_sh[31:0];
         num_ff <= q_mag;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            quo_ff <= q_sat;
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- design/pressure_flow_grid_step_core.sv -----
// Double-banked pressure/flow grid held in three simple dual-port RAMs (one write and
// one registered read per cycle each). Items are taken one at a time with
// start/busy; every item returns exactly one rsp_valid strobe, which the
// receiver must take in that cycle. A read passes through ST_RD_OUT; one whose
// coordinate is outside the grid is answered from idle with status set. Init
// writes every RAM entry of both banks, one per cycle. Step copies each cell
// from the back bank and exchanges flow with its left and upper neighbours,
// each exchange using the bit-serial q16.16 divider; a full 64x64 grid has
// 8064 exchanges. An exchange with a zero divisor skips the divider's steps.
module pressure_flow_grid_step_core #(
   parameter int MAX_WIDTH  = pfgs_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = pfgs_pkg::DEF_MAX_HEIGHT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  pfgs_pkg::pfgs_req_type              req_data,
   output logic                                busy,
   output logic                                rsp_valid,
   output pfgs_pkg::pfgs_rsp_type              rsp_data,
   input  logic                                csr_we,
   input  logic [pfgs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pfgs_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import pfgs_pkg::*;

   localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int AW = 1 + XW + YW;

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_INIT    = 4'd1;
   localparam logic [3:0] ST_COPY_RD = 4'd2;
   localparam logic [3:0] ST_COPY_WR = 4'd3;
   localparam logic [3:0] ST_EX_RD   = 4'd4;
   localparam logic [3:0] ST_EX_M1   = 4'd5;
   localparam logic [3:0] ST_EX_M2   = 4'd6;
   localparam logic [3:0] ST_EX_M3   = 4'd7;
   localparam logic [3:0] ST_EX_M4   = 4'd8;
   localparam logic [3:0] ST_EX_M5   = 4'd9;
   localparam logic [3:0] ST_EX_WA   = 4'd10;
   localparam logic [3:0] ST_EX_WB   = 4'd11;
   localparam logic [3:0] ST_EX_FT   = 4'd12;
   localparam logic [3:0] ST_EX_DIV  = 4'd13;
   localparam logic [3:0] ST_EX_UPD  = 4'd14;
   localparam logic [3:0] ST_RD_OUT  = 4'd15;

   // control state
   logic [3:0]    state_ff, state_in;
   logic          bank_ff, bank_in;
   logic [XW-1:0] x_ff, x_in;
   logic [YW-1:0] y_ff, y_in;
   logic          dir_ff, dir_in;
   logic [AW-1:0] init_cnt_ff, init_cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   pfgs_rsp_type  rsp_data_ff, rsp_data_in;

   // csr registers
   logic [6:0]  gw_ff, gh_ff;
   logic [19:0] fric_ff;
   logic [16:0] fdamp_ff;
   logic [30:0] pinit_ff;

   // exchange payload
   logic signed [31:0] pa_ff, pb_ff, fla_ff, fap_ff, fbp_ff;
   logic signed [52:0] prod_ff;
   logic signed [31:0] nf_ff;
   logic signed [49:0] m1_ff, m2_ff;
   logic signed [31:0] f_ff, app_ff, npa_ff, flt_ff;
   logic signed [63:0] q1_ff;
   logic signed [65:0] q2_ff;

   // ram ports
   logic          p_we, fr_we, fd_we;
   logic [AW-1:0] p_waddr, fl_waddr, p_raddr, fl_raddr;
   logic [31:0]   p_wdata, fl_wdata;
   logic [31:0]   p_rd, fr_rd, fd_rd;

   // divider
   logic               div_start, div_done;
   logic signed [31:0] div_b, div_quo;

   logic [XW:0]        w_eff;
   logic [YW:0]        h_eff;
   logic [XW+YW-1:0]   cell_a, cell_b;
   logic [AW-1:0]      req_addr, t_addr;
   logic               x_last, y_last, rd_out_range;
   logic [16:0]        damp_eff;
   logic signed [17:0] damp_s, omd_s;
   logic signed [31:0] fl_rd_sel, dp, nf_in, f_in, app_in, new_pa, new_pb, upd;
   logic signed [52:0] prod_in;
   logic signed [50:0] fsum;
   logic signed [32:0] lo;
   logic signed [31:0] hi;
   logic signed [33:0] omk;

   // effective grid size
   assign w_eff = (gw_ff > MAX_WIDTH) ? (XW+1)'(MAX_WIDTH) : (XW+1)'(gw_ff);
   assign h_eff = (gh_ff > MAX_HEIGHT) ? (YW+1)'(MAX_HEIGHT) : (YW+1)'(gh_ff);

   // walk position and neighbour
   assign cell_a = {y_ff, x_ff};
   assign cell_b = dir_ff ? {YW'(y_ff - 1'b1), x_ff} : {y_ff, XW'(x_ff - 1'b1)};
   assign x_last = ({1'b0, x_ff} + 1'b1) == w_eff;
   assign y_last = ({1'b0, y_ff} + 1'b1) == h_eff;
   assign t_addr = (f_ff > 32'sd0) ? {bank_ff, cell_b} : {bank_ff, cell_a};

   // read request decode
   assign req_addr     = {bank_ff, YW'(req_data.cell_y), XW'(req_data.cell_x)};
   assign rd_out_range = (req_data.cell_x >= w_eff) || (req_data.cell_y >= h_eff);

   // flow arithmetic
   assign fl_rd_sel = dir_ff ? $signed(fd_rd) : $signed(fr_rd);
   assign damp_eff  = (fdamp_ff > Q_ONE) ? Q_ONE : fdamp_ff;
   assign damp_s    = $signed({1'b0, damp_eff});
   assign omd_s     = $signed({1'b0, Q_ONE}) - damp_s;
   assign dp        = sat32(68'(pa_ff) - 68'(pb_ff));
   assign prod_in   = dp * $signed({1'b0, fric_ff});
   assign nf_in     = sat32(68'(prod_ff >>> 16));
   assign fsum      = 51'(m1_ff) + 51'(m2_ff);
   assign f_in      = sat32(68'(fsum >>> 16));
   assign lo        = (-33'(pb_ff)) >>> 2;
   assign hi        = pa_ff >>> 2;
   assign new_pa    = sat32(68'(fap_ff) - 68'(app_ff));
   assign new_pb    = sat32(68'(fbp_ff) + 68'(app_ff));
   assign div_b     = (f_ff > 32'sd0) ? new_pb : npa_ff;
   assign omk       = $signed({17'd0, Q_ONE}) - 34'(div_quo);
   assign upd       = sat32(68'(q1_ff >>> 16) + 68'(q2_ff >>> 16));

   // clamp applied flow to the pressure bounds
   always_comb begin
      if (f_in > hi) begin
         app_in = hi;
      end else if (f_in < lo) begin
         app_in = 32'(lo);
      end else begin
         app_in = f_in;
      end
   end

   // ram address and write selection
   always_comb begin
      p_raddr  = req_addr;
      fl_raddr = req_addr;
      p_we     = 1'b0;
      fr_we    = 1'b0;
      fd_we    = 1'b0;
      p_waddr  = {bank_ff, cell_a};
      fl_waddr = {bank_ff, cell_a};
      p_wdata  = 32'(pinit_ff);
      fl_wdata = 32'(f_ff);
      unique case (state_ff)
         ST_INIT: begin
            p_we     = 1'b1;
            fr_we    = 1'b1;
            fd_we    = 1'b1;
            p_waddr  = init_cnt_ff;
            fl_waddr = init_cnt_ff;
            fl_wdata = '0;
         end
         ST_COPY_RD: p_raddr = {~bank_ff, cell_a};
         ST_COPY_WR: begin
            p_we    = 1'b1;
            p_wdata = p_rd;
         end
         ST_EX_RD: begin
            p_raddr  = {~bank_ff, cell_b};
            fl_raddr = {~bank_ff, cell_a};
         end
         ST_EX_M1: p_raddr = {bank_ff, cell_a};
         ST_EX_M2: p_raddr = {bank_ff, cell_b};
         ST_EX_WA: begin
            p_we    = 1'b1;
            p_wdata = 32'(new_pa);
            fr_we   = !dir_ff;
            fd_we   = dir_ff;
         end
         ST_EX_WB: begin
            p_we     = 1'b1;
            p_waddr  = {bank_ff, cell_b};
            p_wdata  = 32'(new_pb);
            fl_raddr = {bank_ff, cell_b};
         end
         ST_EX_UPD: begin
            fr_we    = !dir_ff;
            fd_we    = dir_ff;
            fl_waddr = t_addr;
            fl_wdata = 32'(upd);
         end
         default: begin
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      bank_in      = bank_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      dir_in       = dir_ff;
      init_cnt_in  = init_cnt_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      div_start    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               rsp_data_in = '0;
               unique case (req_data.func)
                  FUNC_INIT: begin
                     init_cnt_in = '0;
                     state_in    = ST_INIT;
                  end
                  FUNC_STEP: begin
                     bank_in = ~bank_ff;
                     x_in    = '0;
                     y_in    = '0;
                     if (w_eff == '0 || h_eff == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = ST_COPY_RD;
                     end
                  end
                  FUNC_READ: begin
                     if (rd_out_range) begin
                        rsp_valid_in       = 1'b1;
                        rsp_data_in.status = 1'b1;
                     end else begin
                        state_in = ST_RD_OUT;
                     end
                  end
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end
         ST_INIT: begin
            init_cnt_in = init_cnt_ff + 1'b1;
            if (&init_cnt_ff) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_COPY_RD: state_in = ST_COPY_WR;
         ST_EX_RD:   state_in = ST_EX_M1;
         ST_EX_M1:   state_in = ST_EX_M2;
         ST_EX_M2:   state_in = ST_EX_M3;
         ST_EX_M3:   state_in = ST_EX_M4;
         ST_EX_M4:   state_in = ST_EX_M5;
         ST_EX_M5:   state_in = ST_EX_WA;
         ST_EX_WA:   state_in = ST_EX_WB;
         ST_EX_WB: begin
            div_start = 1'b1;
            state_in  = ST_EX_FT;
         end
         ST_EX_FT:   state_in = ST_EX_DIV;
         ST_EX_DIV: begin
            if (div_done) begin
               state_in = ST_EX_UPD;
            end
         end
         ST_COPY_WR, ST_EX_UPD: begin
            if (state_ff == ST_COPY_WR && x_ff != '0) begin
               dir_in   = 1'b0;
               state_in = ST_EX_RD;
            end else if (!(state_ff == ST_EX_UPD && dir_ff) && y_ff != '0) begin
               dir_in   = 1'b1;
               state_in = ST_EX_RD;
            end else if (!x_last) begin
               x_in     = x_ff + 1'b1;
               state_in = ST_COPY_RD;
            end else if (!y_last) begin
               x_in     = '0;
               y_in     = y_ff + 1'b1;
               state_in = ST_COPY_RD;
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_RD_OUT: begin
            rsp_valid_in           = 1'b1;
            rsp_data_in.pressure   = $signed(p_rd);
            rsp_data_in.flow_right = $signed(fr_rd);
            rsp_data_in.flow_down  = $signed(fd_rd);
            rsp_data_in.status     = 1'b0;
            state_in               = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bank_ff      <= 1'b0;
         x_ff         <= '0;
         y_ff         <= '0;
         dir_ff       <= 1'b0;
         init_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bank_ff      <= bank_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         dir_ff       <= dir_in;
         init_cnt_ff  <= init_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         gw_ff    <= RST_GRID_WIDTH;
         gh_ff    <= RST_GRID_HEIGHT;
         fric_ff  <= RST_FRICTION;
         fdamp_ff <= RST_DAMPING;
         pinit_ff <= RST_INIT_PRESS;
      end else if (csr_we) begin
         case (csr_index)
            CSR_GRID_WIDTH:  gw_ff    <= csr_wdata[6:0];
            CSR_GRID_HEIGHT: gh_ff    <= csr_wdata[6:0];
            CSR_FRICTION:    fric_ff  <= csr_wdata[19:0];
            CSR_DAMPING:     fdamp_ff <= csr_wdata[16:0];
            CSR_INIT_PRESS:  pinit_ff <= csr_wdata[30:0];
            default: begin
            end
         endcase
      end
   end

   // exchange payload captures
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      unique case (state_ff)
         ST_COPY_WR: pa_ff <= $signed(p_rd);
         ST_EX_M1: begin
            pb_ff  <= $signed(p_rd);
            fla_ff <= fl_rd_sel;
         end
         ST_EX_M2: begin
            prod_ff <= prod_in;
            fap_ff  <= $signed(p_rd);
         end
         ST_EX_M3: begin
            nf_ff  <= nf_in;
            fbp_ff <= $signed(p_rd);
         end
         ST_EX_M4: begin
            m1_ff <= fla_ff * damp_s;
            m2_ff <= nf_ff * omd_s;
         end
         ST_EX_M5: begin
            f_ff   <= f_in;
            app_ff <= app_in;
         end
         ST_EX_WA: npa_ff <= new_pa;
         ST_EX_FT: flt_ff <= (f_ff > 32'sd0) ? fl_rd_sel : f_ff;
         ST_EX_DIV: begin
            if (div_done) begin
               q1_ff <= app_ff * div_quo;
               q2_ff <= flt_ff * omk;
            end
         end
         default: begin
         end
      endcase
   end

   pfgs_ram #(.AW(AW), .DW(32)) u_p_ram (
      .clock   (clock),
      .wr_en   (p_we),
      .wr_addr (p_waddr),
      .wr_data (p_wdata),
      .rd_addr (p_raddr),
      .rd_data (p_rd)
   );

   pfgs_ram #(.AW(AW), .DW(32)) u_fr_ram (
      .clock   (clock),
      .wr_en   (fr_we),
      .wr_addr (fl_waddr),
      .wr_data (fl_wdata),
      .rd_addr (fl_raddr),
      .rd_data (fr_rd)
   );

   pfgs_ram #(.AW(AW), .DW(32)) u_fd_ram (
      .clock   (clock),
      .wr_en   (fd_we),
      .wr_addr (fl_waddr),
      .wr_data (fl_wdata),
      .rd_addr (fl_raddr),
      .rd_data (fd_rd)
   );

   pfgs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (f_ff),
      .divisor  (div_b),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- design/pfgs_check.sv -----
module pfgs_check (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   rsp_valid,
   input pfgs_pkg::pfgs_rsp_type rsp_data
);
   import pfgs_pkg::*;

   // an accepted beat either starts work or answers at once
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || rsp_valid)
      else $error("accepted beat neither started work nor answered");

   // finishing work always answers
   a_finish_answers: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(busy) |-> rsp_valid)
      else $error("work ended without a result beat");

   // no result without a preceding beat or work
   a_no_stray_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy) || $past(start))
      else $error("result beat without work");

   // out-of-grid read carries zero values
   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status |-> rsp_data.pressure == 32'sd0
         && rsp_data.flow_right == 32'sd0 && rsp_data.flow_down == 32'sd0)
      else $error("status set with nonzero values");

endmodule

bind pressure_flow_grid_step_core pfgs_check u_pfgs_check (.*);

// ----- dv/tb_pressure_flow_grid_step_core.sv -----
module tb_pressure_flow_grid_step_core;
   import pfgs_pkg::*;

   localparam int GRID_W    = 64;
   localparam int GRID_H    = 64;
   localparam int CELLS     = GRID_W * GRID_H;
   localparam int STALL_MAX = 100000;
   localparam logic [1:0] FUNC_SPARE = 2'd3;

   logic                  clock;
   logic                  reset;
   logic                  start;
   pfgs_req_type          req_data;
   logic                  busy;
   logic                  rsp_valid;
   pfgs_rsp_type          rsp_data;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   pressure_flow_grid_step_core DUT (
      .clock(clock), .reset(reset), .start(start), .req_data(req_data), .busy(busy),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_we(csr_we),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // grid mirror and settings
   logic signed [31:0] press_mirror [2*CELLS];
   logic signed [31:0] fright_mirror[2*CELLS];
   logic signed [31:0] fdown_mirror [2*CELLS];
   logic               front_bank;
   logic [6:0]         width_set, height_set;
   logic [19:0]        friction_set;
   logic [16:0]        damping_set;
   logic [30:0]        init_press_set;

   pfgs_rsp_type pending_rsp[$];
   int           fail_count;
   int           stall_cycles;
   int           burst_left;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic signed [31:0] clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] q16_divide(input longint a, input longint b);
      if (b == 0) return (a > 0) ? 32'sh7fffffff : ((a < 0) ? 32'sh80000000 : 32'sd0);
      return clamp32((a * 65536) / b);
   endfunction

   // flow exchange between a cell and its left or upper neighbour
   task automatic flow_exchange(input int ba, input int fa, input int bb, input int fb,
                                input bit down);
      longint damp, pa, pb, dp, nf, f, lo, hi, app, k, old_t;
      int     t;
      damp = (damping_set > 17'd65536) ? 64'sd65536 : longint'(damping_set);
      pa = longint'(press_mirror[ba]);
      pb = longint'(press_mirror[bb]);
      dp = longint'(clamp32(pa - pb));
      nf = longint'(clamp32((dp * longint'(friction_set)) >>> 16));
      f = longint'(clamp32(((down ? longint'(fdown_mirror[ba]) : longint'(fright_mirror[ba]))
                            * damp + nf * (65536 - damp)) >>> 16));
      lo = (-pb) >>> 2;
      hi = pa >>> 2;
      app = f;
      if (app > hi) app = hi;
      else if (app < lo) app = lo;
      press_mirror[fa] = clamp32(longint'(press_mirror[fa]) - app);
      press_mirror[fb] = clamp32(longint'(press_mirror[fb]) + app);
      if (down) fdown_mirror[fa] = 32'(f);
      else fright_mirror[fa] = 32'(f);
      t = (f > 0) ? fb : fa;
      k = longint'(q16_divide(f, longint'(press_mirror[t])));
      old_t = down ? longint'(fdown_mirror[t]) : longint'(fright_mirror[t]);
      if (down) fdown_mirror[t] = clamp32(((app * k) >>> 16) + ((old_t * (65536 - k)) >>> 16));
      else fright_mirror[t] = clamp32(((app * k) >>> 16) + ((old_t * (65536 - k)) >>> 16));
   endtask

   // expected answer for one accepted command, updating the mirror
   task automatic predict_grid_op(input pfgs_req_type req, output pfgs_rsp_type rsp);
      int w, h, fo, bo, c, a;
      w = (width_set > 7'd64) ? GRID_W : int'(width_set);
      h = (height_set > 7'd64) ? GRID_H : int'(height_set);
      rsp = '0;
      case (req.func)
         FUNC_INIT: begin
            for (int i = 0; i < 2*CELLS; i++) begin
               press_mirror[i]  = {1'b0, init_press_set};
               fright_mirror[i] = '0;
               fdown_mirror[i]  = '0;
            end
         end
         FUNC_STEP: begin
            front_bank = ~front_bank;
            fo = front_bank ? CELLS : 0;
            bo = front_bank ? 0 : CELLS;
            for (int y = 0; y < h; y++) begin
               for (int x = 0; x < w; x++) begin
                  c = y * GRID_W + x;
                  press_mirror[fo+c] = press_mirror[bo+c];
                  if (x > 0) flow_exchange(bo+c, fo+c, bo+c-1, fo+c-1, 1'b0);
                  if (y > 0) flow_exchange(bo+c, fo+c, bo+c-GRID_W, fo+c-GRID_W, 1'b1);
               end
            end
         end
         FUNC_READ: begin
            if (int'(req.cell_x) >= w || int'(req.cell_y) >= h) begin
               rsp.status = 1'b1;
            end else begin
               a = (front_bank ? CELLS : 0) + int'(req.cell_y) * GRID_W + int'(req.cell_x);
               rsp.pressure   = press_mirror[a];
               rsp.flow_right = fright_mirror[a];
               rsp.flow_down  = fdown_mirror[a];
            end
         end
         default: ;
      endcase
   endtask

   // one command beat, honoring the sender burst pattern
   task automatic send_cmd(input logic [1:0] func, input logic [5:0] x, input logic [5:0] y);
      pfgs_req_type req;
      pfgs_rsp_type rsp;
      if (burst_left == 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat ($urandom_range(0, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 20 : $urandom_range(1, 6);
      end
      burst_left--;
      req.func = func;
      req.cell_x = x;
      req.cell_y = y;
      @(negedge clock);
      start = 1'b1;
      req_data = req;
      do @(posedge clock); while (busy);
      predict_grid_op(req, rsp);
      pending_rsp.push_back(rsp);
   endtask

   // wait until every answer is back and the core has gone quiet
   task automatic drain;
      @(negedge clock);
      start = 1'b0;
      wait (pending_rsp.size() == 0);
      repeat (8) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [30:0] value);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      case (idx)
         CSR_GRID_WIDTH:  width_set = value[6:0];
         CSR_GRID_HEIGHT: height_set = value[6:0];
         CSR_FRICTION:    friction_set = value[19:0];
         CSR_DAMPING:     damping_set = value[16:0];
         CSR_INIT_PRESS:  init_press_set = value;
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic set_grid(input int w, input int h, input int fr, input int dm, input int ip);
      drain();
      csr_write(CSR_GRID_WIDTH, 31'(w));
      csr_write(CSR_GRID_HEIGHT, 31'(h));
      csr_write(CSR_FRICTION, 31'(fr));
      csr_write(CSR_DAMPING, 31'(dm));
      csr_write(CSR_INIT_PRESS, 31'(ip));
   endtask

   // init at reset settings, reads at the corners, spare code
   task automatic test_init_and_read;
      send_cmd(FUNC_INIT, 6'd0, 6'd0);
      send_cmd(FUNC_READ, 6'd0, 6'd0);
      send_cmd(FUNC_READ, 6'd63, 6'd63);
      send_cmd(FUNC_READ, 6'd63, 6'd0);
      send_cmd(FUNC_SPARE, 6'd63, 6'd63);
   endtask

   // small grid, full friction, zero damping, top pressure
   task automatic test_small_step;
      set_grid(3, 3, 20'hfffff, 0, 31'h7fffffff);
      send_cmd(FUNC_INIT, 6'd0, 6'd0);
      send_cmd(FUNC_STEP, 6'd0, 6'd0);
      send_cmd(FUNC_READ, 6'd2, 6'd2);
      send_cmd(FUNC_READ, 6'd3, 6'd0);
      send_cmd(FUNC_STEP, 6'd0, 6'd0);
      send_cmd(FUNC_READ, 6'd1, 6'd1);
   endtask

   // damping above one, zero pressure gives zero divisors
   task automatic test_damping_and_zero_pressure;
      set_grid(2, 2, 0, 17'h1ffff, 0);
      send_cmd(FUNC_INIT, 6'd0, 6'd0);
      send_cmd(FUNC_STEP, 6'd0, 6'd0);
      send_cmd(FUNC_READ, 6'd1, 6'd1);
      set_grid(2, 2, 1, 65536, 1);
      send_cmd(FUNC_STEP, 6'd0, 6'd0);
      send_cmd(FUNC_READ, 6'd0, 6'd1);
   endtask

   // empty grid and oversized dimensions
   task automatic test_grid_shapes;
      set_grid(0, 0, 16384, 32768, 65536);
      send_cmd(FUNC_STEP, 6'd0, 6'd0);
      send_cmd(FUNC_READ, 6'd0, 6'd0);
      set_grid(127, 1, 16384, 32768, 65536);
      send_cmd(FUNC_STEP, 6'd0, 6'd0);
      send_cmd(FUNC_READ, 6'd63, 6'd0);
      send_cmd(FUNC_READ, 6'd0, 6'd1);
      set_grid(1, 127, 16384, 32768, 65536);
      send_cmd(FUNC_STEP, 6'd0, 6'd0);
      send_cmd(FUNC_READ, 6'd0, 6'd63);
      send_cmd(FUNC_READ, 6'd1, 6'd5);
   endtask

   // random settings phases with mixed commands
   task automatic test_random_mix;
      int w, h, pick;
      for (int n = 0; n < 75; n++) begin
         if (n % 12 == 0) begin
            w = $urandom_range(0, 5);
            h = $urandom_range(0, 5);
            if ($urandom_range(0, 5) == 0) begin
               w = $urandom_range(60, 127);
               h = 1;
            end
            set_grid(w, h, $urandom_range(0, 20'hfffff), $urandom_range(0, 17'h1ffff),
                     int'($urandom & 31'h7fffffff));
            if ($urandom_range(0, 2) == 0) send_cmd(FUNC_INIT, 6'($urandom), 6'($urandom));
         end
         pick = $urandom_range(0, 99);
         if (pick < 55)
            send_cmd(FUNC_READ,
                     $urandom_range(0, 1) ? 6'($urandom_range(0, 6)) : 6'($urandom),
                     $urandom_range(0, 1) ? 6'($urandom_range(0, 6)) : 6'($urandom));
         else if (pick < 85) send_cmd(FUNC_STEP, 6'($urandom), 6'($urandom));
         else if (pick < 93) send_cmd(FUNC_SPARE, 6'($urandom), 6'($urandom));
         else send_cmd(FUNC_INIT, 6'($urandom), 6'($urandom));
      end
   endtask

   // result check and watchdog
   always @(posedge clock) begin
      pfgs_rsp_type want;
      if (reset) begin
         stall_cycles <= 0;
      end else begin
         if (rsp_valid || (start && !busy)) stall_cycles <= 0;
         else stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_MAX) begin
            $display("tb_pressure_flow_grid_step_core NOT OK");
            $finish;
         end
         if (rsp_valid) begin
            if (pending_rsp.size() == 0) begin
               $error("result beat with nothing expected");
               fail_count++;
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_data.pressure !== want.pressure) begin
                  $error("pressure exp %0d got %0d", want.pressure, rsp_data.pressure);
                  fail_count++;
               end
               if (rsp_data.flow_right !== want.flow_right) begin
                  $error("flow_right exp %0d got %0d", want.flow_right, rsp_data.flow_right);
                  fail_count++;
               end
               if (rsp_data.flow_down !== want.flow_down) begin
                  $error("flow_down exp %0d got %0d", want.flow_down, rsp_data.flow_down);
                  fail_count++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status exp %0d got %0d", want.status, rsp_data.status);
                  fail_count++;
               end
            end
         end
      end
   end

   initial begin
      fail_count = 0;
      burst_left = 0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      front_bank = 1'b0;
      width_set = RST_GRID_WIDTH;
      height_set = RST_GRID_HEIGHT;
      friction_set = RST_FRICTION;
      damping_set = RST_DAMPING;
      init_press_set = RST_INIT_PRESS;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_init_and_read();
      test_small_step();
      test_damping_and_zero_pressure();
      test_grid_shapes();
      test_random_mix();
      drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_pressure_flow_grid_step_core OK");
      end else begin
         $display("tb_pressure_flow_grid_step_core NOT OK");
      end
      $finish;
   end

endmodule
